[design/joystick_axis_deadzone_scaler_macros.svh]
// assertion macros shared by the joystick axis scaler modules
// expects signals named clk and arst_n in the module that uses them
`ifndef JOYSTICK_AXIS_DEADZONE_SCALER_MACROS_SVH
`define JOYSTICK_AXIS_DEADZONE_SCALER_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked on every edge outside reset
`define JADS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("jads check failed");
// checked on every edge, reset included
`define JADS_ASSERT_NR(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("jads reset check failed");
`else
`define JADS_ASSERT(lbl, prop)
`define JADS_ASSERT_NR(lbl, prop)
`endif
`endif

[design/jads_pkg.sv]
// shared widths, register codes, reset values and types of the joystick axis scaler
// no dependencies
package jads_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int BAND_W     = SAMPLE_W - 1;
	localparam int QUOT_W     = SAMPLE_W - 1;
	localparam int FULL_SCALE = 511;
	localparam int PROD_W     = SAMPLE_W + QUOT_W;
	localparam int CFG_IDX_W  = 3;

	localparam logic [SAMPLE_W-1:0] MIN_RST  = SAMPLE_W'(0);
	localparam logic [SAMPLE_W-1:0] MID_RST  = SAMPLE_W'(512);
	localparam logic [SAMPLE_W-1:0] MAX_RST  = SAMPLE_W'(1023);
	localparam logic [BAND_W-1:0]   BAND_RST = BAND_W'(25);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_MIN = 3'd0,
		CFG_X_MID = 3'd1,
		CFG_X_MAX = 3'd2,
		CFG_Y_MIN = 3'd3,
		CFG_Y_MID = 3'd4,
		CFG_Y_MAX = 3'd5,
		CFG_BAND  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] mid;
		logic [SAMPLE_W-1:0] hi;
	} axis_cal_t;

	typedef struct packed {
		axis_cal_t         x;
		axis_cal_t         y;
		logic [BAND_W-1:0] band;
	} cal_t;

	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] value;
	} axis_res_t;

endpackage

[design/joystick_axis_deadzone_scaler.sv]
// top level of the two-axis joystick scaler with dead band
// depends on jads_pkg, jads_regs, jads_lane, jads_merge and the assertion macro header
`include "joystick_axis_deadzone_scaler_macros.svh"

// One item is a pair of raw samples (sample_x, sample_y), taken at every edge with
// start high; busy is never raised, so a new item can enter every clock cycle. Each
// axis goes through its own lane: a front stage picks the side of the dead band and
// the span, a second stage scales by full scale, and three stages of restoring
// division resolve three quotient bits each. Each item passes the lane registers
// s1 to s5 and the output register of jads_merge; result_strobe is high for one cycle
// and the item is gone at the next edge. The receiver cannot stall the block, so it
// must take every strobe. hid_axis_y is axis_y negated. Calibration registers are
// written through the cfg port (ready always high) and are meant to change only while
// no item is in flight.
module joystick_axis_deadzone_scaler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item in
	input  logic                                 start,
	output logic                                 busy,
	input  logic [jads_pkg::SAMPLE_W-1:0]        sample_x,
	input  logic [jads_pkg::SAMPLE_W-1:0]        sample_y,
	// item out
	output logic                                 result_strobe,
	output logic signed [jads_pkg::SAMPLE_W-1:0] axis_x,
	output logic signed [jads_pkg::SAMPLE_W-1:0] axis_y,
	output logic signed [jads_pkg::SAMPLE_W-1:0] hid_axis_y,
	// calibration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [jads_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [jads_pkg::SAMPLE_W-1:0]        cfg_data
);
	import jads_pkg::*;

	cal_t      cal;
	axis_res_t res_x, res_y;
	logic      accept;

	// fully pipelined: never busy, config always taken
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	jads_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cal      (cal)
	);

	// x lane
	jads_lane u_lane_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.sample   (sample_x),
		.cal      (cal.x),
		.band     (cal.band),
		.res      (res_x)
	);

	// y lane
	jads_lane u_lane_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.sample   (sample_y),
		.cal      (cal.y),
		.band     (cal.band),
		.res      (res_y)
	);

	// merge both lanes into one registered result item
	jads_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_x      (res_x),
		.res_y      (res_y),
		.strobe     (result_strobe),
		.axis_x     (axis_x),
		.axis_y     (axis_y),
		.hid_axis_y (hid_axis_y)
	);

	// fixed latency, both directions
	`JADS_ASSERT(a_lat_fwd, start && !busy |-> ##6 result_strobe)
	`JADS_ASSERT(a_lat_back, result_strobe |-> $past(start && !busy, 6))
	// saturation keeps every axis off the most negative code
	`JADS_ASSERT(a_no_min, result_strobe |-> axis_x != {1'b1, (SAMPLE_W - 1)'(0)} && axis_y != {1'b1, (SAMPLE_W - 1)'(0)})
	// nothing comes out right after reset
	`JADS_ASSERT_NR(a_rst_quiet, !arst_n |=> !result_strobe)

endmodule

[design/jads_regs.sv]
// calibration register file of the joystick axis scaler
// depends on jads_pkg
module jads_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [jads_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [jads_pkg::SAMPLE_W-1:0]  wr_data,
	output jads_pkg::cal_t                 cal
);
	import jads_pkg::*;

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.x    <= '{lo: MIN_RST, mid: MID_RST, hi: MAX_RST};
			cal_q.y    <= '{lo: MIN_RST, mid: MID_RST, hi: MAX_RST};
			cal_q.band <= BAND_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_X_MIN: cal_q.x.lo  <= wr_data;
				CFG_X_MID: cal_q.x.mid <= wr_data;
				CFG_X_MAX: cal_q.x.hi  <= wr_data;
				CFG_Y_MIN: cal_q.y.lo  <= wr_data;
				CFG_Y_MID: cal_q.y.mid <= wr_data;
				CFG_Y_MAX: cal_q.y.hi  <= wr_data;
				CFG_BAND:  cal_q.band  <= wr_data[BAND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cal = cal_q;

endmodule

[design/jads_lane.sv]
// one axis lane: dead band test, span select, scaling and pipelined division
// depends on jads_pkg and the assertion macro header
`include "joystick_axis_deadzone_scaler_macros.svh"
module jads_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [jads_pkg::SAMPLE_W-1:0] sample,
	input  jads_pkg::axis_cal_t           cal,
	input  logic [jads_pkg::BAND_W-1:0]   band,
	output jads_pkg::axis_res_t           res
);
	import jads_pkg::*;

	typedef enum logic [1:0] {
		SIDE_ZERO,
		SIDE_POS,
		SIDE_NEG
	} side_t;

	typedef struct packed {
		side_t side;
		logic  force_fs;
		logic  over;
	} lane_ctrl_t;

	// three restoring steps from quotient bit top downward
	function automatic logic [PROD_W+2:0] div3(
		input logic [PROD_W-1:0]   r_in,
		input logic [SAMPLE_W-1:0] v,
		input int                  top
	);
		logic [PROD_W-1:0] r;
		logic [PROD_W-1:0] dv;
		logic [2:0]        qb;
		r  = r_in;
		qb = '0;
		for (int i = 0; i < 3; i++) begin
			dv = PROD_W'(v) << (top - i);
			if (r >= dv) begin
				r         = r - dv;
				qb[2 - i] = 1'b1;
			end
		end
		return {qb, r};
	endfunction

	// front end
	logic [SAMPLE_W:0]   up_edge, low_sum, lo_edge;
	logic                is_up, is_dn, up_force, dn_force;
	logic [SAMPLE_W-1:0] mag_up, span_up, mag_dn, span_dn;
	lane_ctrl_t          ctrl_d;
	logic [SAMPLE_W-1:0] mag_d, span_d;

	always_comb begin
		up_edge  = {1'b0, cal.mid} + {2'b0, band};
		low_sum  = {1'b0, sample} + {2'b0, band};
		lo_edge  = {1'b0, cal.lo} + {2'b0, band};
		is_up    = {1'b0, sample} >= up_edge;
		is_dn    = low_sum <= {1'b0, cal.mid};
		up_force = {1'b0, cal.hi} <= up_edge;
		dn_force = {1'b0, cal.mid} <= lo_edge;
		mag_up   = SAMPLE_W'({1'b0, sample} - up_edge);
		span_up  = SAMPLE_W'({1'b0, cal.hi} - up_edge);
		mag_dn   = SAMPLE_W'({1'b0, cal.mid} - low_sum);
		span_dn  = SAMPLE_W'({1'b0, cal.mid} - lo_edge);
		ctrl_d.over = 1'b0;
		if (is_up) begin
			ctrl_d.side     = SIDE_POS;
			ctrl_d.force_fs = up_force;
			mag_d           = mag_up;
			span_d          = span_up;
		end else if (is_dn) begin
			ctrl_d.side     = SIDE_NEG;
			ctrl_d.force_fs = dn_force;
			mag_d           = mag_dn;
			span_d          = span_dn;
		end else begin
			ctrl_d.side     = SIDE_ZERO;
			ctrl_d.force_fs = 1'b0;
			mag_d           = '0;
			span_d          = '0;
		end
	end

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	lane_ctrl_t          ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	logic [SAMPLE_W-1:0] mag_s1;
	logic [SAMPLE_W-1:0] span_s1, span_s2, span_s3, span_s4;
	logic [PROD_W-1:0]   prod_s2, rem_s3, rem_s4, rem_s5;
	logic [QUOT_W-1:0]   q_s3, q_s4, q_s5;

	// division steps
	logic                over_d;
	logic [PROD_W+2:0]   st3, st4, st5;

	always_comb begin
		over_d = prod_s2 >= {span_s2, QUOT_W'(0)};
		st3    = div3(prod_s2, span_s2, QUOT_W - 1);
		st4    = div3(rem_s3, span_s3, QUOT_W - 4);
		st5    = div3(rem_s4, span_s4, QUOT_W - 7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s1 <= ctrl_d;
		mag_s1  <= mag_d;
		span_s1 <= span_d;

		ctrl_s2 <= ctrl_s1;
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(FULL_SCALE);
		span_s2 <= span_s1;

		ctrl_s3 <= '{side: ctrl_s2.side, force_fs: ctrl_s2.force_fs, over: over_d};
		rem_s3  <= st3[PROD_W-1:0];
		q_s3    <= {st3[PROD_W+2:PROD_W], (QUOT_W - 3)'(0)};
		span_s3 <= span_s2;

		ctrl_s4 <= ctrl_s3;
		rem_s4  <= st4[PROD_W-1:0];
		q_s4    <= {q_s3[QUOT_W-1:QUOT_W-3], st4[PROD_W+2:PROD_W], 3'b000};
		span_s4 <= span_s3;

		ctrl_s5 <= ctrl_s4;
		rem_s5  <= st5[PROD_W-1:0];
		q_s5    <= {q_s4[QUOT_W-1:3], st5[PROD_W+2:PROD_W]};
	end

	// sign and full scale
	logic [QUOT_W-1:0]          mag_out;
	logic signed [SAMPLE_W-1:0] val;

	always_comb begin
		mag_out = (ctrl_s5.force_fs || ctrl_s5.over) ? QUOT_W'(FULL_SCALE) : q_s5;
		case (ctrl_s5.side)
			SIDE_POS: val = signed'({1'b0, mag_out});
			SIDE_NEG: val = -signed'({1'b0, mag_out});
			default:  val = '0;
		endcase
	end

	assign res = '{valid: v_s5, value: val};

	// remainder stays below the divisor weight still to be resolved
	`JADS_ASSERT(a_rem_s4, v_s4 && ctrl_s4.side != SIDE_ZERO && !ctrl_s4.force_fs && !ctrl_s4.over |-> rem_s4 < (PROD_W'(span_s4) << (QUOT_W - 6)))
	`JADS_ASSERT(a_rem_s5, v_s5 && ctrl_s5.side != SIDE_ZERO && !ctrl_s5.force_fs && !ctrl_s5.over |-> rem_s5 < PROD_W'($past(span_s4)))
	`JADS_ASSERT(a_zero_s5, v_s5 && ctrl_s5.side == SIDE_ZERO |-> !ctrl_s5.force_fs)

endmodule

[design/jads_merge.sv]
// output stage: joins the two lane results into one registered item
// depends on jads_pkg
module jads_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  jads_pkg::axis_res_t                  res_x,
	input  jads_pkg::axis_res_t                  res_y,
	output logic                                 strobe,
	output logic signed [jads_pkg::SAMPLE_W-1:0] axis_x,
	output logic signed [jads_pkg::SAMPLE_W-1:0] axis_y,
	output logic signed [jads_pkg::SAMPLE_W-1:0] hid_axis_y
);
	import jads_pkg::*;

	logic                       strobe_q;
	logic signed [SAMPLE_W-1:0] axis_x_q, axis_y_q, hid_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res_x.valid & res_y.valid;
		end
	end

	always_ff @(posedge clk) begin
		axis_x_q <= res_x.value;
		axis_y_q <= res_y.value;
		hid_y_q  <= -res_y.value;
	end

	assign strobe     = strobe_q;
	assign axis_x     = axis_x_q;
	assign axis_y     = axis_y_q;
	assign hid_axis_y = hid_y_q;

endmodule

[bench/joystick_axis_deadzone_scaler_test.sv]
// self-checking bench for the two-axis joystick scaler with dead band
// depends on jads_pkg and the joystick_axis_deadzone_scaler rtl, nothing else
module joystick_axis_deadzone_scaler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import jads_pkg::*;

	localparam real CLK_PERIOD = 12.0;
	// delay from a taken item to its result strobe, used for the final drain
	localparam int LATENCY = 6;
	// cycles with no handshake of any kind before the run is called hung
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 75;
	// index 7 is not mapped to any calibration register
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

	typedef logic signed [SAMPLE_W-1:0] deflect_t;

	// one result item as the block should give it
	typedef struct {
		deflect_t x;
		deflect_t y;
		deflect_t hid;
	} axis_triple_t;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	// directed stimulus row: either a sample pair or a register write
	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [SAMPLE_W-1:0]  value_a;
		logic [SAMPLE_W-1:0]  value_b;
		bit                   fixed;
		deflect_t             fixed_x;
		deflect_t             fixed_y;
	} stim_row_t;

	typedef enum {CAL_TYPICAL, CAL_WIDE, CAL_ZERO, CAL_RAW, CAL_ONES} cal_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [SAMPLE_W-1:0]  sample_x = '0;
	logic [SAMPLE_W-1:0]  sample_y = '0;
	logic                 result_strobe;
	deflect_t             axis_x;
	deflect_t             axis_y;
	deflect_t             hid_axis_y;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SAMPLE_W-1:0]  cfg_data = '0;

	// typed-in expectation travelling alongside the item on the bus
	logic                 pair_fixed = 1'b0;
	deflect_t             pair_fixed_x = '0;
	deflect_t             pair_fixed_y = '0;

	// bench copy of the calibration registers
	cal_t                 cal_now;
	// results still owed by the block, oldest first
	axis_triple_t         pending_axes[$];
	stim_row_t            stim_rows[$];
	int                   error_count = 0;
	int                   stall_cycles = 0;

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	joystick_axis_deadzone_scaler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.result_strobe(result_strobe),
		.axis_x       (axis_x),
		.axis_y       (axis_y),
		.hid_axis_y   (hid_axis_y),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// one axis: zero inside the band, linear past the band edge,
	// full scale on an empty or inverted span, clamped to +-full scale
	function automatic deflect_t map_one_axis(logic [SAMPLE_W-1:0] sample, axis_cal_t cal,
			logic [BAND_W-1:0] band);
		int s;
		int mid;
		int b;
		int span;
		int q;
		s = sample;
		mid = cal.mid;
		b = band;
		if (s >= mid + b) begin
			// upper side wins the tie at the centre when the band is zero
			span = int'(cal.hi) - mid - b;
			if (span <= 0)
				return deflect_t'(FULL_SCALE);
			q = (s - mid - b) * FULL_SCALE / span;
		end else if (s <= mid - b) begin
			span = mid - b - int'(cal.lo);
			if (span <= 0)
				return deflect_t'(-FULL_SCALE);
			q = (s - mid + b) * FULL_SCALE / span;
		end else begin
			return '0;
		end
		// sample past the calibrated extreme
		if (q > FULL_SCALE)
			q = FULL_SCALE;
		if (q < -FULL_SCALE)
			q = -FULL_SCALE;
		return deflect_t'(q);
	endfunction

	function automatic axis_triple_t predict_axes(logic [SAMPLE_W-1:0] sx,
			logic [SAMPLE_W-1:0] sy, cal_t cal);
		axis_triple_t t;
		t.x = map_one_axis(sx, cal.x, cal.band);
		t.y = map_one_axis(sy, cal.y, cal.band);
		// hid axis runs the other way
		t.hid = -t.y;
		return t;
	endfunction

	// random sample: half uniform, half clustered around the centre and band edges
	function automatic logic [SAMPLE_W-1:0] pick_sample(int mid, int band);
		int reach;
		int r;
		if ($urandom_range(1) == 0)
			return SAMPLE_W'($urandom_range(0, 1023));
		reach = band + 40;
		r = mid + int'($urandom_range(0, 2 * reach)) - reach;
		if (r < 0)
			r = 0;
		if (r > 1023)
			r = 1023;
		return r[SAMPLE_W-1:0];
	endfunction

	function automatic void add_item(logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy,
			bit fixed, int ex, int ey);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.reg_idx = '0;
		row.value_a = sx;
		row.value_b = sy;
		row.fixed = fixed;
		row.fixed_x = deflect_t'(ex);
		row.fixed_y = deflect_t'(ey);
		stim_rows.push_back(row);
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.reg_idx = idx;
		row.value_a = data;
		row.value_b = '0;
		row.fixed = 1'b0;
		row.fixed_x = '0;
		row.fixed_y = '0;
		stim_rows.push_back(row);
	endfunction

	// item and register write capture: values on the bus just before the edge
	always @(posedge clk) begin : capture_mon
		axis_triple_t t;
		if (arst_n && start && !busy) begin
			if (pair_fixed) begin
				t.x = pair_fixed_x;
				t.y = pair_fixed_y;
				t.hid = -pair_fixed_y;
			end else begin
				t = predict_axes(sample_x, sample_y, cal_now);
			end
			pending_axes.push_back(t);
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_X_MIN: cal_now.x.lo = cfg_data;
				CFG_X_MID: cal_now.x.mid = cfg_data;
				CFG_X_MAX: cal_now.x.hi = cfg_data;
				CFG_Y_MIN: cal_now.y.lo = cfg_data;
				CFG_Y_MID: cal_now.y.mid = cfg_data;
				CFG_Y_MAX: cal_now.y.hi = cfg_data;
				// band only keeps its low bits
				CFG_BAND:  cal_now.band = cfg_data[BAND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	task automatic check_field(string name, deflect_t want, deflect_t got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
				want, got);
			error_count++;
		end
	endtask

	// every strobe must match the oldest owed result
	always @(posedge clk) begin : result_mon
		axis_triple_t t;
		if (arst_n && result_strobe) begin
			if (pending_axes.size() == 0) begin
				$display("%0t ns: unexpected item, expected none, actual %0d/%0d/%0d",
					$time, axis_x, axis_y, hid_axis_y);
				error_count++;
			end else begin
				t = pending_axes.pop_front();
				check_field("axis_x", t.x, axis_x);
				check_field("axis_y", t.y, axis_y);
				check_field("hid_axis_y", t.hid, hid_axis_y);
			end
		end
	end

	// hang detector: counts edges where no handshake of any kind happened
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// present a pair and hold it until taken; start is left high for a following item
	task automatic send_pair(logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy, bit fixed,
			deflect_t fx, deflect_t fy);
		start <= 1'b1;
		sample_x <= sx;
		sample_y <= sy;
		pair_fixed <= fixed;
		pair_fixed_x <= fx;
		pair_fixed_y <= fy;
		do
			@(posedge clk);
		while (busy);
	endtask

	// sender hiccup: on about 7 in 100 calls, when allowed, start is dropped for a random gap
	task automatic sender_gap(bit allowed);
		if (allowed && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 2))
				@(posedge clk);
		end
	endtask

	// hold the sender until every owed result is back
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_axes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// full calibration for one random phase, unmapped index slipped in the middle
	task automatic program_cal(cal_kind_t kind);
		logic [SAMPLE_W-1:0] v[7];
		case (kind)
			CAL_TYPICAL: begin
				v[0] = SAMPLE_W'($urandom_range(0, 300));
				v[1] = SAMPLE_W'($urandom_range(400, 620));
				v[2] = SAMPLE_W'($urandom_range(700, 1023));
				v[3] = SAMPLE_W'($urandom_range(0, 300));
				v[4] = SAMPLE_W'($urandom_range(400, 620));
				v[5] = SAMPLE_W'($urandom_range(700, 1023));
				v[6] = SAMPLE_W'($urandom_range(0, 60));
			end
			CAL_WIDE: begin
				v[0] = '0;
				v[1] = SAMPLE_W'($urandom_range(0, 1023));
				v[2] = '1;
				v[3] = '0;
				v[4] = SAMPLE_W'($urandom_range(0, 1023));
				v[5] = '1;
				v[6] = SAMPLE_W'($urandom_range(0, 500));
			end
			CAL_ZERO: begin
				foreach (v[i])
					v[i] = '0;
			end
			CAL_ONES: begin
				foreach (v[i])
					v[i] = '1;
			end
			default: begin
				// inconsistent settings allowed, band top bit included
				foreach (v[i])
					v[i] = SAMPLE_W'($urandom_range(0, 1023));
			end
		endcase
		write_reg(CFG_X_MIN, v[0]);
		write_reg(CFG_X_MID, v[1]);
		write_reg(CFG_X_MAX, v[2]);
		write_reg(CFG_UNMAPPED, SAMPLE_W'($urandom_range(0, 1023)));
		write_reg(CFG_Y_MIN, v[3]);
		write_reg(CFG_Y_MID, v[4]);
		write_reg(CFG_Y_MAX, v[5]);
		write_reg(CFG_BAND, v[6]);
	endtask

	initial begin : stimulus
		stim_row_t row;
		int phase;
		int n;

		cal_now.x.lo = MIN_RST;
		cal_now.x.mid = MID_RST;
		cal_now.x.hi = MAX_RST;
		cal_now.y.lo = MIN_RST;
		cal_now.y.mid = MID_RST;
		cal_now.y.hi = MAX_RST;
		cal_now.band = BAND_RST;

		// reset calibration: 0 / 512 / 1023, band 25
		add_item(512, 512, 1, 0, 0);
		add_item(0, 0, 1, -511, -511);
		add_item(1023, 1023, 1, 511, 511);
		// exactly on the band edges
		add_item(537, 487, 1, 0, 0);
		add_item(536, 488, 1, 0, 0);
		add_item(600, 400, 0, 0, 0);
		add_item(1023, 0, 1, 511, -511);
		// zero band: the centre takes the upper side and still gives zero
		add_cfg(CFG_BAND, 0);
		add_item(512, 512, 1, 0, 0);
		add_item(513, 511, 0, 0, 0);
		// unmapped index must leave every register alone
		add_cfg(CFG_UNMAPPED, 10'h155);
		add_item(0, 1023, 1, -511, 511);
		// empty x spans, inverted y spans
		add_cfg(CFG_X_MIN, 512);
		add_cfg(CFG_X_MAX, 512);
		add_cfg(CFG_Y_MIN, 900);
		add_cfg(CFG_Y_MAX, 100);
		add_item(513, 513, 1, 511, 511);
		add_item(511, 511, 1, -511, -511);
		add_item(512, 512, 1, 511, 511);
		// narrow calibration so samples run past the extremes
		add_cfg(CFG_X_MIN, 200);
		add_cfg(CFG_X_MID, 500);
		add_cfg(CFG_X_MAX, 800);
		add_cfg(CFG_Y_MIN, 300);
		add_cfg(CFG_Y_MID, 600);
		add_cfg(CFG_Y_MAX, 900);
		add_cfg(CFG_BAND, 20);
		add_item(1000, 50, 1, 511, -511);
		add_item(700, 450, 0, 0, 0);
		add_item(250, 700, 0, 0, 0);
		// all-ones write to the band keeps 511, wider than any sane setting
		add_cfg(CFG_BAND, 10'h3ff);
		add_item(0, 1023, 1, 0, 0);
		add_item(1023, 0, 1, 511, -511);

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				write_reg(row.reg_idx, row.value_a);
			end else begin
				sender_gap(1'b1);
				send_pair(row.value_a, row.value_b, row.fixed, row.fixed_x, row.fixed_y);
			end
		end

		// random phases, each under a fresh calibration
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			program_cal(cal_kind_t'(phase % 5));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// mid-phase pause with the pipeline drained
				if (phase == 1 && n == PHASE_ITEMS / 2)
					wait_idle();
				// phases 2 and 3 run back to back with no gaps
				sender_gap(phase != 2 && phase != 3);
				send_pair(pick_sample(cal_now.x.mid, cal_now.band),
					pick_sample(cal_now.y.mid, cal_now.band), 1'b0, '0, '0);
			end
		end

		wait_idle();
		repeat (LATENCY + 4)
			@(posedge clk);
		if (pending_axes.size() != 0) begin
			$display("%0t ns: %0d items missing, expected %0d/%0d/%0d, actual none",
				$time, pending_axes.size(), pending_axes[0].x, pending_axes[0].y,
				pending_axes[0].hid);
			error_count++;
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/jads_pkg.sv
design/jads_regs.sv
design/jads_lane.sv
design/jads_merge.sv
design/joystick_axis_deadzone_scaler.sv
bench/joystick_axis_deadzone_scaler_test.sv
